>>> hdl/dpd_pkg.sv
package dpd_pkg;

    localparam int DATA_WIDTH       = 32;
    localparam int FRAC_BITS        = 16;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int COEF_W           = 48;
    localparam int COEF_FRAC        = 16;
    localparam int WIDE_W           = 64;
    localparam int IDX_W            = 3;
    localparam int TRIG_FRAC        = 30;

    localparam logic [64:0] PI_Q62 = 65'h0C90FDAA22168C234;
    localparam logic [64:0] TWO_PI_Q =
        (PI_Q62 + (65'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
    localparam int ANG_W = $clog2(TWO_PI_Q);

    localparam int RED_U_W = DATA_WIDTH + 1;
    localparam logic [64:0] RED_OFS =
        ((65'd1 << (DATA_WIDTH - 1)) + TWO_PI_Q - 65'd1) / TWO_PI_Q * TWO_PI_Q;
    localparam logic [64:0] RED_RECIP = (65'd1 << RED_U_W) / TWO_PI_Q;
    localparam int RECIP_W = $clog2(RED_RECIP + 65'd1);

    localparam int ZW  = 36;
    localparam int XW  = 34;
    localparam int ZSH = TRIG_FRAC - FRAC_BITS;
    localparam logic [64:0] PI30   = (PI_Q62 + (65'd1 << 31)) >> 32;
    localparam logic [64:0] TWO30  = (PI_Q62 + (65'd1 << 30)) >> 31;
    localparam logic [64:0] HALF30 = (PI_Q62 + (65'd1 << 32)) >> 33;
    localparam logic [64:0] CORDIC_GAIN = 65'd652032874;

    localparam int MUL_LAT = 4;
    localparam int RED_LAT = 4;
    localparam int DIV_LAT = WIDE_W + 2;
    localparam int DEN_W   = COEF_W + TRIG_FRAC - COEF_FRAC;
    localparam int DS_SH   = 46 - FRAC_BITS;

    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam wide_t WIDE_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam wide_t DATA_MAX = (wide_t'(1) <<< (DATA_WIDTH - 1)) - wide_t'(1);
    localparam wide_t DATA_MIN = -DATA_MAX - wide_t'(1);

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_A     = 3'd0,
        REG_COEF_B1    = 3'd1,
        REG_COEF_B     = 3'd2,
        REG_COEF_C     = 3'd3,
        REG_COEF_D     = 3'd4,
        REG_COEF_E     = 3'd5,
        REG_MASS_RATIO = 3'd6
    } cfg_reg_t;

    function automatic wide_t negsat(input wide_t a);
        return (a == WIDE_MIN) ? WIDE_MAX : -a;
    endfunction

    function automatic wide_t addsat(input wide_t a, input wide_t b);
        logic signed [WIDE_W:0] s;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1])
            return s[WIDE_W] ? WIDE_MIN : WIDE_MAX;
        return s[WIDE_W-1:0];
    endfunction

    function automatic logic [DATA_WIDTH:0] clamp_data(input wide_t v);
        if (v > DATA_MAX)
            return {1'b1, DATA_MAX[DATA_WIDTH-1:0]};
        if (v < DATA_MIN)
            return {1'b1, DATA_MIN[DATA_WIDTH-1:0]};
        return {1'b0, v[DATA_WIDTH-1:0]};
    endfunction

    function automatic logic [63:0] atan_q30(input int idx);
        logic [63:0] sum;
        logic [63:0] term;
        sum = 64'd0;
        if (idx == 0)
            return 64'(((PI_Q62 >> 2) + (65'd1 << 31)) >> 32);
        for (int k = 0; (2 * k + 1) * idx < 63; k++)
        begin
            term = ((64'd1 << 62) >> ((2 * k + 1) * idx)) / 64'(2 * k + 1);
            if ((k % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return (sum + (64'd1 << 31)) >> 32;
    endfunction

endpackage

>>> hdl/dpd_delay.sv
module dpd_delay
    import dpd_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] pipe_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
                pipe_reg[i] <= pipe_reg[i-1];
        end
    end

    assign dout = pipe_reg[DEPTH-1];

endmodule

>>> hdl/dpd_reduce.sv
module dpd_reduce
    import dpd_pkg::*;
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [DATA_WIDTH-1:0] angle_in,
    output logic [ANG_W-1:0]             angle_out
);

    logic [RED_U_W-1:0]         u_reg, u_d1_reg;
    logic [RED_U_W+RECIP_W-1:0] prod_reg;
    logic [ANG_W:0]             rem_reg;
    logic [ANG_W-1:0]           angle_reg;
    logic [RECIP_W-1:0]         quot;
    logic [RED_U_W-1:0]         u_next;
    logic [ANG_W:0]             rem_next;

    assign u_next   = RED_U_W'(64'(angle_in) + 64'(RED_OFS));
    assign quot     = RECIP_W'(prod_reg >> RED_U_W);
    assign rem_next = (ANG_W+1)'(u_d1_reg - RED_U_W'(quot * TWO_PI_Q[RED_U_W-1:0]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg     <= u_next;
            u_d1_reg  <= u_reg;
            prod_reg  <= u_reg * RED_RECIP[RECIP_W-1:0];
            rem_reg   <= rem_next;
            angle_reg <= (rem_reg >= TWO_PI_Q[ANG_W:0])
                       ? ANG_W'(rem_reg - TWO_PI_Q[ANG_W:0]) : ANG_W'(rem_reg);
        end
    end

    assign angle_out = angle_reg;

endmodule

>>> hdl/dpd_cordic.sv
module dpd_cordic
    import dpd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [ANG_W-1:0]     angle,
    output logic signed [XW-1:0] sin_out,
    output logic signed [XW-1:0] cos_out
);

    localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI30);
    localparam logic signed [ZW-1:0] TWO_Z  = ZW'(TWO30);
    localparam logic signed [ZW-1:0] HALF_Z = ZW'(HALF30);

    logic signed [ZW-1:0] zw_reg;
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0] z_reg [CORDIC_STEPS+1];
    logic                 neg_reg [CORDIC_STEPS+1];
    logic signed [XW-1:0] sin_reg, cos_reg;

    assign z0 = $signed(ZW'(angle)) <<< ZSH;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zw_reg <= (z0 >= PI_Z) ? z0 - TWO_Z : z0;
            x_reg[0] <= XW'(CORDIC_GAIN);
            y_reg[0] <= '0;
            if (zw_reg > HALF_Z)
            begin
                z_reg[0]   <= zw_reg - PI_Z;
                neg_reg[0] <= 1'b1;
            end
            else if (zw_reg < -HALF_Z)
            begin
                z_reg[0]   <= zw_reg + PI_Z;
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]   <= zw_reg;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [ZW-1:0] AT = ZW'(atan_q30(i));
        logic signed [XW-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    z_reg[i+1] <= z_reg[i] - AT;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    z_reg[i+1] <= z_reg[i] + AT;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg <= neg_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

>>> hdl/dpd_mulsat.sv
module dpd_mulsat
    import dpd_pkg::*;
#(
    parameter int SHIFT = 16
)
(
    input  logic  clk,
    input  logic  en,
    input  wide_t a_in,
    input  wide_t b_in,
    output wide_t prod_out
);

    localparam int HW = WIDE_W / 2;

    logic [WIDE_W-1:0]   x_reg, y_reg;
    logic [WIDE_W-1:0]   p00_reg, p01_reg, p10_reg, p11_reg;
    logic [2*WIDE_W-1:0] full_reg;
    logic                neg1_reg, neg2_reg, neg3_reg;
    wide_t               out_reg;
    logic [2*WIDE_W-1:0] q;
    logic                rest;
    logic                hi_nz;
    logic [WIDE_W-1:0]   lo;
    wide_t               out_next;

    assign rest  = |full_reg[SHIFT-1:0];
    assign q     = (full_reg >> SHIFT) + (2*WIDE_W)'(neg3_reg && rest);
    assign hi_nz = |q[2*WIDE_W-1:WIDE_W];
    assign lo    = q[WIDE_W-1:0];

    always_comb
    begin
        if (!neg3_reg)
            out_next = (hi_nz || lo[WIDE_W-1]) ? WIDE_MAX : wide_t'(lo);
        else if (hi_nz || (lo[WIDE_W-1] && (|lo[WIDE_W-2:0])))
            out_next = WIDE_MIN;
        else
            out_next = wide_t'(-lo);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= a_in[WIDE_W-1] ^ b_in[WIDE_W-1];
            x_reg    <= a_in[WIDE_W-1] ? -a_in : a_in;
            y_reg    <= b_in[WIDE_W-1] ? -b_in : b_in;
            neg2_reg <= neg1_reg;
            p00_reg  <= x_reg[HW-1:0] * y_reg[HW-1:0];
            p01_reg  <= x_reg[HW-1:0] * y_reg[WIDE_W-1:HW];
            p10_reg  <= x_reg[WIDE_W-1:HW] * y_reg[HW-1:0];
            p11_reg  <= x_reg[WIDE_W-1:HW] * y_reg[WIDE_W-1:HW];
            neg3_reg <= neg2_reg;
            full_reg <= (2*WIDE_W)'(p00_reg)
                      + ((2*WIDE_W)'(p01_reg) << HW)
                      + ((2*WIDE_W)'(p10_reg) << HW)
                      + ((2*WIDE_W)'(p11_reg) << WIDE_W);
            out_reg  <= out_next;
        end
    end

    assign prod_out = out_reg;

endmodule

>>> hdl/dpd_divide.sv
module dpd_divide
    import dpd_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  wide_t            num,
    input  logic [DEN_W-1:0] den,
    output wide_t            quo
);

    localparam int HI_W = TRIG_FRAC;

    logic [WIDE_W-1:0] mag;
    logic [HI_W-1:0]   mag_hi;
    logic              ovf;
    logic [DEN_W-1:0]  rem_reg [WIDE_W+1];
    logic [WIDE_W-1:0] sh_reg  [WIDE_W+1];
    logic [DEN_W-1:0]  d_reg   [WIDE_W+1];
    logic              neg_reg [WIDE_W+1];
    logic              ovf_reg [WIDE_W+1];
    wide_t             quo_reg;
    logic [WIDE_W-1:0] qv;
    wide_t             quo_next;

    assign mag    = num[WIDE_W-1] ? -num : num;
    assign mag_hi = mag[WIDE_W-1:WIDE_W-TRIG_FRAC];
    assign ovf    = (DEN_W'(mag_hi) >= den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf ? '0 : DEN_W'(mag_hi);
            sh_reg[0]  <= mag << TRIG_FRAC;
            d_reg[0]   <= den;
            neg_reg[0] <= num[WIDE_W-1];
            ovf_reg[0] <= ovf;
        end
    end

    for (genvar i = 0; i < WIDE_W; i++)
    begin : g_bit
        logic [DEN_W:0] trial;
        logic           fits;
        assign trial = {rem_reg[i], sh_reg[i][WIDE_W-1]};
        assign fits  = trial >= {1'b0, d_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= fits ? DEN_W'(trial - {1'b0, d_reg[i]}) : DEN_W'(trial);
                sh_reg[i+1]  <= {sh_reg[i][WIDE_W-2:0], fits};
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    assign qv = sh_reg[WIDE_W];

    always_comb
    begin
        if (ovf_reg[WIDE_W])
            quo_next = neg_reg[WIDE_W] ? WIDE_MIN : WIDE_MAX;
        else if (!neg_reg[WIDE_W])
            quo_next = qv[WIDE_W-1] ? WIDE_MAX : wide_t'(qv);
        else if (qv[WIDE_W-1] && (|qv[WIDE_W-2:0]))
            quo_next = WIDE_MIN;
        else
            quo_next = wide_t'(-qv);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

>>> hdl/double_pendulum_derivative_unit.sv
// The 64-step restoring divider and the CORDIC chain dominate the pipeline depth.
// Throughput: one item per cycle while the two-entry output buffer has room; when it
// is full the whole pipeline and s_axis_tready stall until the receiver takes an item.
// Reset: rst_n clears all valid bits, the output buffer and the coefficients
// (mass ratio to 2.0, others to zero); configuration writes are always ready.
module double_pendulum_derivative_unit
    import dpd_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // angle_upper, angle_lower, momentum_upper, momentum_lower
    input  logic [4*DATA_WIDTH-1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // rate_angle_upper, rate_angle_lower, rate_momentum_upper, rate_momentum_lower
    output logic [4*DATA_WIDTH-1:0] m_axis_tdata,
    // saturated_flag
    output logic [0:0]              m_axis_tuser,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]       cfg_data
);

    localparam int COR_LAT = CORDIC_STEPS + 3;
    localparam int T_DIFF  = RED_LAT + 1;
    localparam int TA      = T_DIFF + COR_LAT;
    localparam int TB      = TA + MUL_LAT;
    localparam int TC      = TB + MUL_LAT;
    localparam int TD      = TC + 1;
    localparam int TE      = TD + DIV_LAT;
    localparam int TG      = TE + 3 * MUL_LAT;
    localparam int LAT     = TG + 2;
    localparam int DW      = DATA_WIDTH;
    localparam int OUT_W   = 4 * DW + 1;

    logic [COEF_W-1:0] coef_a_reg, coef_b1_reg, coef_b_reg, coef_c_reg;
    logic [COEF_W-1:0] coef_d_reg, coef_e_reg, coef_mr_reg;
    logic [LAT-1:0]    valid_reg;
    logic              adv;

    logic [OUT_W-1:0]  buf_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg  <= '0;
            coef_b1_reg <= '0;
            coef_b_reg  <= '0;
            coef_c_reg  <= '0;
            coef_d_reg  <= '0;
            coef_e_reg  <= '0;
            coef_mr_reg <= COEF_W'(131072);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COEF_A:     coef_a_reg  <= cfg_data;
                REG_COEF_B1:    coef_b1_reg <= cfg_data;
                REG_COEF_B:     coef_b_reg  <= cfg_data;
                REG_COEF_C:     coef_c_reg  <= cfg_data;
                REG_COEF_D:     coef_d_reg  <= cfg_data;
                REG_COEF_E:     coef_e_reg  <= cfg_data;
                REG_MASS_RATIO: coef_mr_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // advance whole pipe while the output buffer has room
    assign adv           = (count_reg != 2'd2);
    assign s_axis_tready = adv;
    assign push          = adv && valid_reg[LAT-1];
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
    end

    // angle reduction and difference
    logic [ANG_W-1:0] r1, r2, r1d_reg, r2d_reg, rd_reg;

    dpd_reduce u_red1 (.clk(clk), .en(adv), .angle_in(s_axis_tdata[DW-1:0]), .angle_out(r1));
    dpd_reduce u_red2 (.clk(clk), .en(adv), .angle_in(s_axis_tdata[2*DW-1:DW]), .angle_out(r2));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1d_reg <= r1;
            r2d_reg <= r2;
            rd_reg  <= (r1 >= r2) ? ANG_W'(r1 - r2)
                     : ANG_W'({1'b0, r1} + TWO_PI_Q[ANG_W:0] - {1'b0, r2});
        end
    end

    logic signed [XW-1:0] s1, s2, sd, cd, sd_g;

    dpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cor1
        (.clk(clk), .en(adv), .angle(r1d_reg), .sin_out(s1), .cos_out());
    dpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cor2
        (.clk(clk), .en(adv), .angle(r2d_reg), .sin_out(s2), .cos_out());
    dpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cord
        (.clk(clk), .en(adv), .angle(rd_reg), .sin_out(sd), .cos_out(cd));

    logic [2*DW-1:0] p_a, p_b;
    wide_t p1_a, p2_a, p1_b, p2_b;

    dpd_delay #(.WIDTH(2*DW), .DEPTH(TA)) u_dly_pa
        (.clk(clk), .en(adv), .din(s_axis_tdata[4*DW-1:2*DW]), .dout(p_a));
    dpd_delay #(.WIDTH(2*DW), .DEPTH(MUL_LAT)) u_dly_pb
        (.clk(clk), .en(adv), .din(p_a), .dout(p_b));

    assign p1_a = WIDE_W'($signed(p_a[DW-1:0]));
    assign p2_a = WIDE_W'($signed(p_a[2*DW-1:DW]));
    assign p1_b = WIDE_W'($signed(p_b[DW-1:0]));
    assign p2_b = WIDE_W'($signed(p_b[2*DW-1:DW]));

    wide_t cd_w, s1_w, s2_w, sd_w;
    wide_t ca_w, cb1_w, cb_w, cc_w, cdc_w, ce_w;

    assign cd_w  = WIDE_W'(cd);
    assign s1_w  = WIDE_W'(s1);
    assign s2_w  = WIDE_W'(s2);
    assign sd_w  = WIDE_W'(sd_g);
    assign ca_w  = wide_t'({{(WIDE_W-COEF_W){1'b0}}, coef_a_reg});
    assign cb1_w = wide_t'({{(WIDE_W-COEF_W){1'b0}}, coef_b1_reg});
    assign cb_w  = wide_t'({{(WIDE_W-COEF_W){1'b0}}, coef_b_reg});
    assign cc_w  = wide_t'({{(WIDE_W-COEF_W){1'b0}}, coef_c_reg});
    assign cdc_w = wide_t'({{(WIDE_W-COEF_W){1'b0}}, coef_d_reg});
    assign ce_w  = wide_t'({{(WIDE_W-COEF_W){1'b0}}, coef_e_reg});

    // first product layer
    wide_t bm, ap1, cp2, csq, ds1, es2;

    dpd_mulsat #(.SHIFT(TRIG_FRAC)) u_mul_bm
        (.clk(clk), .en(adv), .a_in(cb_w), .b_in(cd_w), .prod_out(bm));
    dpd_mulsat #(.SHIFT(COEF_FRAC)) u_mul_ap1
        (.clk(clk), .en(adv), .a_in(ca_w), .b_in(p1_a), .prod_out(ap1));
    dpd_mulsat #(.SHIFT(COEF_FRAC)) u_mul_cp2
        (.clk(clk), .en(adv), .a_in(cc_w), .b_in(p2_a), .prod_out(cp2));
    dpd_mulsat #(.SHIFT(TRIG_FRAC)) u_mul_csq
        (.clk(clk), .en(adv), .a_in(cd_w), .b_in(cd_w), .prod_out(csq));
    dpd_mulsat #(.SHIFT(DS_SH)) u_mul_ds1
        (.clk(clk), .en(adv), .a_in(cdc_w), .b_in(s1_w), .prod_out(ds1));
    dpd_mulsat #(.SHIFT(DS_SH)) u_mul_es2
        (.clk(clk), .en(adv), .a_in(ce_w), .b_in(s2_w), .prod_out(es2));

    // second product layer and denominator
    wide_t bp1, bp2;
    logic [2*WIDE_W-1:0] apcp_c;
    wide_t den_raw;
    logic [DEN_W-1:0] den_reg, den_d;

    dpd_mulsat #(.SHIFT(COEF_FRAC)) u_mul_bp2
        (.clk(clk), .en(adv), .a_in(bm), .b_in(p2_b), .prod_out(bp2));
    dpd_mulsat #(.SHIFT(COEF_FRAC)) u_mul_bp1
        (.clk(clk), .en(adv), .a_in(bm), .b_in(p1_b), .prod_out(bp1));
    dpd_delay #(.WIDTH(2*WIDE_W), .DEPTH(MUL_LAT)) u_dly_apcp
        (.clk(clk), .en(adv), .din({cp2, ap1}), .dout(apcp_c));

    assign den_raw = wide_t'({{(WIDE_W-DEN_W){1'b0}}, coef_mr_reg,
                              {(TRIG_FRAC-COEF_FRAC){1'b0}}}) - csq;

    always_ff @(posedge clk)
    begin
        if (adv)
            den_reg <= (den_raw < wide_t'(1)) ? DEN_W'(1) : DEN_W'(den_raw);
    end

    dpd_delay #(.WIDTH(DEN_W), .DEPTH(TD - TB - 1)) u_dly_den
        (.clk(clk), .en(adv), .din(den_reg), .dout(den_d));

    wide_t n1_reg, n2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n1_reg <= addsat(wide_t'(apcp_c[WIDE_W-1:0]), negsat(bp2));
            n2_reg <= addsat(wide_t'(apcp_c[2*WIDE_W-1:WIDE_W]), negsat(bp1));
        end
    end

    wide_t q1, q2;

    dpd_divide u_div1 (.clk(clk), .en(adv), .num(n1_reg), .den(den_d), .quo(q1));
    dpd_divide u_div2 (.clk(clk), .en(adv), .num(n2_reg), .den(den_d), .quo(q2));

    // coupling term
    wide_t q2_f, t1, t2, kk;
    logic [2*WIDE_W-1:0] q_h, dses_g;

    dpd_delay #(.WIDTH(WIDE_W), .DEPTH(MUL_LAT)) u_dly_q2
        (.clk(clk), .en(adv), .din(q2), .dout(q2_f));
    dpd_delay #(.WIDTH(XW), .DEPTH(TE + 2 * MUL_LAT - TA)) u_dly_sd
        (.clk(clk), .en(adv), .din(sd), .dout(sd_g));
    dpd_delay #(.WIDTH(2*WIDE_W), .DEPTH(TG - TB)) u_dly_dses
        (.clk(clk), .en(adv), .din({es2, ds1}), .dout(dses_g));
    dpd_delay #(.WIDTH(2*WIDE_W), .DEPTH(TG + 1 - TE)) u_dly_q
        (.clk(clk), .en(adv), .din({q2, q1}), .dout(q_h));

    dpd_mulsat #(.SHIFT(COEF_FRAC)) u_mul_t1
        (.clk(clk), .en(adv), .a_in(cb1_w), .b_in(q1), .prod_out(t1));
    dpd_mulsat #(.SHIFT(FRAC_BITS)) u_mul_t2
        (.clk(clk), .en(adv), .a_in(t1), .b_in(q2_f), .prod_out(t2));
    dpd_mulsat #(.SHIFT(TRIG_FRAC)) u_mul_kk
        (.clk(clk), .en(adv), .a_in(t2), .b_in(sd_w), .prod_out(kk));

    wide_t rp1_reg, rp2_reg;
    logic [DW:0] c0, c1, c2, c3;
    logic [OUT_W-1:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp1_reg <= addsat(negsat(kk), negsat(wide_t'(dses_g[WIDE_W-1:0])));
            rp2_reg <= addsat(kk, negsat(wide_t'(dses_g[2*WIDE_W-1:WIDE_W])));
        end
    end

    assign c0 = clamp_data(wide_t'(q_h[WIDE_W-1:0]));
    assign c1 = clamp_data(wide_t'(q_h[2*WIDE_W-1:WIDE_W]));
    assign c2 = clamp_data(rp1_reg);
    assign c3 = clamp_data(rp2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg <= {c0[DW] | c1[DW] | c2[DW] | c3[DW],
                        c3[DW-1:0], c2[DW-1:0], c1[DW-1:0], c0[DW-1:0]};
    end

    // output buffer
    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = buf_reg[rd_ptr_reg][4*DW-1:0];
    assign m_axis_tuser  = buf_reg[rd_ptr_reg][4*DW];

endmodule

>>> test/double_pendulum_derivative_checker.sv
module double_pendulum_derivative_checker
    import dpd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [4*DATA_WIDTH-1:0] s_axis_tdata,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [4*DATA_WIDTH-1:0] m_axis_tdata,
    input  logic [0:0]              m_axis_tuser,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [COEF_W-1:0]       cfg_data,
    output int                      errors,
    output int                      pending
);

    typedef struct {
        logic [DATA_WIDTH-1:0] rate[4];
        logic                  sat;
    } rates_t;

    localparam longint L_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint L_MIN = 64'sh8000_0000_0000_0000;

    rates_t      rate_q[$];
    longint      atan_lut[40];
    logic [47:0] k_a, k_b1, k_b, k_c, k_d, k_e, k_ratio;

    assign pending = rate_q.size();

    initial
    begin
        logic [63:0] sum;
        logic [63:0] term;
        errors = 0;
        atan_lut[0] = longint'(((PI_Q62 >> 2) + (65'd1 << 31)) >> 32);
        for (int i = 1; i < 40; i++)
        begin
            sum = 64'd0;
            for (int k = 0; (2 * k + 1) * i < 63; k++)
            begin
                term = ((64'd1 << 62) >> ((2 * k + 1) * i)) / 64'(2 * k + 1);
                sum = (k % 2 == 1) ? sum - term : sum + term;
            end
            atan_lut[i] = longint'((sum + (64'd1 << 31)) >> 32);
        end
    end

    function automatic longint fx_mul(input longint a, input longint b, input int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> sh;
        if (p[127:63] != {65{p[127]}})
            return p[127] ? L_MIN : L_MAX;
        return p[63:0];
    endfunction

    function automatic longint fx_div(input longint n, input longint d);
        logic signed [127:0] ns;
        logic [127:0] m, q;
        ns = n;
        m = (ns < 0) ? -ns : ns;
        q = (m << TRIG_FRAC) / 128'(d);
        if (n >= 0)
            return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? L_MAX : longint'(q[63:0]);
        return (q > 128'h8000_0000_0000_0000) ? L_MIN : longint'(~q[63:0] + 64'd1);
    endfunction

    function automatic longint fx_add(input longint a, input longint b);
        if (b > 0 && a > L_MAX - b)
            return L_MAX;
        if (b < 0 && a < L_MIN - b)
            return L_MIN;
        return a + b;
    endfunction

    function automatic longint fx_neg(input longint a);
        return (a == L_MIN) ? L_MAX : -a;
    endfunction

    function automatic void cordic_trig(input longint r, output longint sn, output longint cs);
        longint z, x, y, xs, ys;
        logic   flip;
        z = r << ZSH;
        x = longint'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (z >= longint'(PI30))
            z -= longint'(TWO30);
        if (z > longint'(HALF30))
        begin
            z -= longint'(PI30);
            flip = 1'b1;
        end
        else if (z < -longint'(HALF30))
        begin
            z += longint'(PI30);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF && i < 40; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_lut[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_lut[i];
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic rates_t predict_rates(input logic [4*DATA_WIDTH-1:0] st);
        rates_t res;
        longint tp, r1, r2, rd, p1, p2, s1, c1, s2, c2, sd, cd;
        longint bm, n1, n2, den, kk, v[4];
        tp = longint'(TWO_PI_Q);
        r1 = longint'(signed'(st[31:0])) % tp;
        r2 = longint'(signed'(st[63:32])) % tp;
        if (r1 < 0)
            r1 += tp;
        if (r2 < 0)
            r2 += tp;
        p1 = longint'(signed'(st[95:64]));
        p2 = longint'(signed'(st[127:96]));
        rd = r1 - r2;
        if (rd < 0)
            rd += tp;
        cordic_trig(r1, s1, c1);
        cordic_trig(r2, s2, c2);
        cordic_trig(rd, sd, cd);
        bm = fx_mul(longint'(k_b), cd, 30);
        n1 = fx_add(fx_mul(longint'(k_a), p1, 16), fx_neg(fx_mul(bm, p2, 16)));
        n2 = fx_add(fx_mul(longint'(k_c), p2, 16), fx_neg(fx_mul(bm, p1, 16)));
        den = (longint'(k_ratio) << 14) - fx_mul(cd, cd, 30);
        if (den < 1)
            den = 1;
        v[0] = fx_div(n1, den);
        v[1] = fx_div(n2, den);
        kk = fx_mul(fx_mul(fx_mul(longint'(k_b1), v[0], 16), v[1], FRAC_BITS), sd, 30);
        v[2] = fx_add(fx_neg(kk), fx_neg(fx_mul(longint'(k_d), s1, DS_SH)));
        v[3] = fx_add(kk, fx_neg(fx_mul(longint'(k_e), s2, DS_SH)));
        res.sat = 1'b0;
        for (int j = 0; j < 4; j++)
        begin
            if (v[j] > 64'sd2147483647)
            begin
                v[j] = 64'sd2147483647;
                res.sat = 1'b1;
            end
            if (v[j] < -64'sd2147483648)
            begin
                v[j] = -64'sd2147483648;
                res.sat = 1'b1;
            end
            res.rate[j] = v[j][31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rates_t want;
        if (!rst_n)
        begin
            k_a     <= '0;
            k_b1    <= '0;
            k_b     <= '0;
            k_c     <= '0;
            k_d     <= '0;
            k_e     <= '0;
            k_ratio <= 48'd131072;
            rate_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rate_q.size() == 0)
                    report_mismatch("unexpected item", '0, m_axis_tdata[31:0]);
                else
                begin
                    want = rate_q.pop_front();
                    for (int j = 0; j < 4; j++)
                        if (m_axis_tdata[32*j +: 32] !== want.rate[j])
                            report_mismatch($sformatf("rate %0d", j), want.rate[j],
                                            m_axis_tdata[32*j +: 32]);
                    if (m_axis_tuser[0] !== want.sat)
                        report_mismatch("saturated", 32'(want.sat), 32'(m_axis_tuser[0]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                rate_q.push_back(predict_rates(s_axis_tdata));
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_COEF_A:     k_a     <= cfg_data;
                    REG_COEF_B1:    k_b1    <= cfg_data;
                    REG_COEF_B:     k_b     <= cfg_data;
                    REG_COEF_C:     k_c     <= cfg_data;
                    REG_COEF_D:     k_d     <= cfg_data;
                    REG_COEF_E:     k_e     <= cfg_data;
                    REG_MASS_RATIO: k_ratio <= cfg_data;
                    default: ;
                endcase
        end
    end

endmodule

>>> test/double_pendulum_derivative_unit_tb.sv
module double_pendulum_derivative_unit_tb;
    import dpd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 140;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [4*DATA_WIDTH-1:0] s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [4*DATA_WIDTH-1:0] m_axis_tdata;
    logic [0:0]              m_axis_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [COEF_W-1:0]       cfg_data = '0;

    int   errors;
    int   pending;
    int   cycles = 0;
    bit   no_gaps = 1'b0;
    bit   hold_req = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    double_pendulum_derivative_unit u_dut (.*);

    double_pendulum_derivative_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 14);
    endfunction

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = draw_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_state(input logic [31:0] au, input logic [31:0] al,
                              input logic [31:0] mu, input logic [31:0] ml);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ml, mu, al, au};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_coefs(input logic [47:0] v[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_data  <= v[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_angle(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1048576)) - 524288);
            default: return 32'($signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic logic [31:0] pick_momentum(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1310720)) - 655360);
            default: return 32'($signed($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic random_states(input int count);
        int mode;
        for (int n = 0; n < count; n++)
        begin
            mode = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2);
            send_state(pick_angle(mode), pick_angle(mode),
                       pick_momentum(mode), pick_momentum(mode));
        end
    endtask

    initial
    begin
        logic [47:0] coefs[8];
        logic [31:0] angles[9];
        logic [31:0] moms[5];
        angles = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd411775,
                   -32'sd411775, 32'd205887, 32'd102944, -32'sd102944};
        moms = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, -32'sd65536};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients: only the angle path is exercised
        for (int i = 0; i < 5; i++)
            send_state(angles[i], angles[8 - i], moms[i], moms[4 - i]);
        settle();

        // unit masses and lengths, g = 9.81
        coefs = '{48'd65536, 48'd65536, 48'd65536, 48'd131072,
                  48'd1285816, 48'd642908, 48'd131072, 48'd12345};
        write_coefs(coefs);
        for (int i = 0; i < 9; i++)
            send_state(angles[i], angles[(i + 3) % 9], moms[i % 5], moms[(i + 2) % 5]);
        for (int i = 0; i < 5; i++)
            send_state(32'd102944, 32'd0, moms[i], moms[i]);
        random_states(100);
        settle();

        // every coefficient at its maximum, ratio at the singular minimum
        coefs = '{default: 48'hFFFF_FFFF_FFFF};
        coefs[REG_MASS_RATIO] = 48'd65536;
        write_coefs(coefs);
        for (int i = 0; i < 5; i++)
            send_state(angles[i], angles[i], moms[i], moms[4 - i]);
        no_gaps = 1'b1;
        random_states(100);
        no_gaps = 1'b0;
        settle();

        // back-pressure: receiver holds off while items keep coming
        coefs = '{48'd32768, 48'd98304, 48'd43690, 48'd196608,
                  48'd2000000, 48'd700000, 48'd196608, 48'd0};
        write_coefs(coefs);
        hold_req = 1'b1;
        random_states(120);
        settle();

        for (int ph = 0; ph < 3; ph++)
        begin
            foreach (coefs[i])
                coefs[i] = 48'({$urandom(), $urandom()} >> $urandom_range(0, 40));
            if (coefs[REG_MASS_RATIO] < 48'd65536)
                coefs[REG_MASS_RATIO] = 48'd65536 + coefs[REG_MASS_RATIO];
            write_coefs(coefs);
            no_gaps = (ph == 1);
            random_states(100);
            no_gaps = 1'b0;
            settle();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> double_pendulum_derivative_unit.f
hdl/dpd_pkg.sv
hdl/dpd_delay.sv
hdl/dpd_reduce.sv
hdl/dpd_cordic.sv
hdl/dpd_mulsat.sv
hdl/dpd_divide.sv
hdl/double_pendulum_derivative_unit.sv
test/double_pendulum_derivative_checker.sv
test/double_pendulum_derivative_unit_tb.sv
